[src/mesf_pkg.sv]
package mesf_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int ALPHA_W    = 17;
    localparam int THRESH_W   = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int FRAC_SHIFT = 16;
    // signed alpha (ALPHA_W+1) times a difference of two samples (SAMPLE_W+1)
    localparam int PROD_W     = ALPHA_W + 1 + SAMPLE_W + 1;

    localparam int WINDOW_SIZE_DEF   = 5;
    localparam int HISTORY_DEPTH_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THRESHOLD = 1'd1;

    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd19661;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'd65536;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd256;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic push;
        logic clear;
    } t_win_req;

    typedef struct packed {
        logic last;
        logic done;
    } t_win_rsp;

    typedef struct packed {
        logic write;
        logic clear;
    } t_hist_req;

    typedef struct packed {
        logic done;
        logic stable;
    } t_hist_rsp;

endpackage

[src/median_ema_stability_filter.sv]
// Median / moving-average weight filter with a stability window.
//
// Input channel (i_in_valid / o_in_stall): one beat carries i_func and
// i_sample_value. A sample beat goes into the median window; a restart beat
// clears the window, the average and the history fill.
// Output channel (o_out_valid / i_out_stall): one beat per completed window,
// the new average and the stable flag. Configuration writes (i_cfg_we) set
// the blend weight and the stable threshold; write them only while idle.
// A sample that does not close the window, or a restart, is accepted without
// a stall. A window-closing sample runs the median search over the window RAM
// (one candidate after another, one RAM read per compare), then the blend
// (skipped for the first window after a restart or reset, which seeds the
// average) and the write and scan of the history RAM. The block holds
// o_in_stall high while working on a window. A finished beat sits in the
// output register while the next window is collected; a new result waits
// in the block while the receiver stalls.
// Reset clears all control state and the configuration to its defaults.
module median_ema_stability_filter #(
    parameter int WINDOW_SIZE   = mesf_pkg::WINDOW_SIZE_DEF,
    parameter int HISTORY_DEPTH = mesf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mesf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mesf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_func,
    input  logic signed [mesf_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mesf_pkg::SAMPLE_W-1:0] o_filtered_weight,
    output logic                                 o_stable_flag
);
    import mesf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MED   = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_HWR   = 7'b0010000,
        S_HWAIT = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                      r_state;
    logic [ALPHA_W-1:0]          r_ema_alpha;
    logic [THRESH_W-1:0]         r_stable_threshold;
    logic signed [SAMPLE_W-1:0]  r_avg;
    logic                        r_seeded;
    logic signed [PROD_W-1:0]    r_prod;
    logic                        r_res_stable;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_weight;
    logic                        r_out_stable;

    t_win_req                    win_req;
    t_win_rsp                    win_rsp;
    t_hist_req                   hist_req;
    t_hist_rsp                   hist_rsp;
    logic signed [SAMPLE_W-1:0]  median;
    logic                        in_acc;
    logic                        out_load;
    logic [ALPHA_W-1:0]          alpha_sat;
    logic signed [SAMPLE_W:0]    diff;
    logic signed [PROD_W-1:0]    prod;

    assign in_acc         = i_in_valid && (r_state == S_IDLE);
    assign win_req.push   = in_acc && (i_func == FUNC_SAMPLE);
    assign win_req.clear  = in_acc && (i_func == FUNC_RESTART);
    assign hist_req.clear = win_req.clear;
    assign hist_req.write = (r_state == S_HWR);

    mesf_median #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (win_req),
        .i_sample (i_sample_value),
        .o_rsp    (win_rsp),
        .o_median (median)
    );

    mesf_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (hist_req),
        .i_avg       (r_avg),
        .i_threshold (r_stable_threshold),
        .o_rsp       (hist_rsp)
    );

    // a*m + (1-a)*avg == avg + a*(m - avg); the floor shift keeps it exact
    assign alpha_sat = (r_ema_alpha > ALPHA_ONE) ? ALPHA_ONE : r_ema_alpha;
    assign diff      = $signed({median[SAMPLE_W-1], median})
                     - $signed({r_avg[SAMPLE_W-1], r_avg});
    assign prod      = $signed({1'b0, alpha_sat}) * diff;

    assign out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_alpha        <= ALPHA_RESET;
            r_stable_threshold <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EMA_ALPHA:        r_ema_alpha        <= i_cfg_data[ALPHA_W-1:0];
                CFG_STABLE_THRESHOLD: r_stable_threshold <= i_cfg_data[THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avg       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_weight <= r_avg;
                r_out_stable <= r_res_stable;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (win_req.clear) begin
                        r_avg    <= '0;
                        r_seeded <= 1'b0;
                    end else if (win_req.push && win_rsp.last) begin
                        r_state <= S_MED;
                    end
                end
                S_MED: begin
                    if (win_rsp.done) begin
                        if (r_seeded) begin
                            r_state <= S_MUL;
                        end else begin
                            r_avg    <= median;
                            r_seeded <= 1'b1;
                            r_state  <= S_HWR;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_avg   <= r_avg + r_prod[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];
                    r_state <= S_HWR;
                end
                S_HWR: begin
                    r_state <= S_HWAIT;
                end
                S_HWAIT: begin
                    if (hist_rsp.done) begin
                        r_res_stable <= hist_rsp.stable;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_filtered_weight = r_out_weight;
    assign o_stable_flag     = r_out_stable;

endmodule

[src/mesf_ram.sv]
module mesf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mesf_median.sv]
module mesf_median #(
    parameter int WINDOW_SIZE = mesf_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mesf_pkg::t_win_req                   i_req,
    input  logic signed [mesf_pkg::SAMPLE_W-1:0] i_sample,
    output mesf_pkg::t_win_rsp                   o_rsp,
    output logic signed [mesf_pkg::SAMPLE_W-1:0] o_median
);
    import mesf_pkg::*;

    localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = $clog2(WINDOW_SIZE + 1);
    localparam logic [CW-1:0] LAST = CW'(WINDOW_SIZE - 1);
    localparam logic [CW-1:0] MID  = CW'(WINDOW_SIZE / 2);
    localparam logic [CW-1:0] SIZE = CW'(WINDOW_SIZE);

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_LOADX = 5'b00010,
        M_GETX  = 5'b00100,
        M_SCAN  = 5'b01000,
        M_CHECK = 5'b10000
    } t_mstate;

    t_mstate                     r_state;
    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               r_i;
    logic [CW-1:0]               r_j;
    logic [CW-1:0]               r_k;
    logic [CW-1:0]               r_lt;
    logic [CW-1:0]               r_le;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic signed [SAMPLE_W-1:0]  r_median;
    logic                        r_done;

    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic signed [SAMPLE_W-1:0]  rd_val;
    logic                        lt_hit;
    logic                        le_hit;

    mesf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_SIZE),
        .AW    (AW)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.push),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_j[AW-1:0];
        case (r_state)
            M_LOADX: begin
                ram_re    = 1'b1;
                ram_raddr = r_i[AW-1:0];
            end
            M_GETX: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            M_SCAN: begin
                ram_re    = (r_j != SIZE);
                ram_raddr = r_j[AW-1:0];
            end
            default: begin
                ram_re    = 1'b0;
            end
        endcase
    end

    assign rd_val = ram_rdata;
    assign lt_hit = (rd_val < r_x);
    assign le_hit = (rd_val <= r_x);

    // candidate x sits at sorted position MID when #(<x) <= MID < #(<=x)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.clear) begin
                        r_fill <= '0;
                    end else if (i_req.push) begin
                        if (r_fill == LAST) begin
                            r_fill  <= '0;
                            r_i     <= '0;
                            r_state <= M_LOADX;
                        end else begin
                            r_fill <= r_fill + CW'(1);
                        end
                    end
                end
                M_LOADX: begin
                    r_state <= M_GETX;
                end
                M_GETX: begin
                    r_x     <= rd_val;
                    r_j     <= CW'(1);
                    r_k     <= '0;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_state <= M_SCAN;
                end
                M_SCAN: begin
                    r_lt <= r_lt + CW'(lt_hit);
                    r_le <= r_le + CW'(le_hit);
                    r_k  <= r_k + CW'(1);
                    if (r_j != SIZE) begin
                        r_j <= r_j + CW'(1);
                    end
                    if (r_k == LAST) begin
                        r_state <= M_CHECK;
                    end
                end
                M_CHECK: begin
                    if (r_lt <= MID && r_le > MID) begin
                        r_median <= r_x;
                        r_done   <= 1'b1;
                        r_state  <= M_IDLE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= M_LOADX;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.last = (r_fill == LAST);
    assign o_rsp.done = r_done;
    assign o_median   = r_median;

endmodule

[src/mesf_hist.sv]
module mesf_hist #(
    parameter int HISTORY_DEPTH = mesf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mesf_pkg::t_hist_req                  i_req,
    input  logic signed [mesf_pkg::SAMPLE_W-1:0] i_avg,
    input  logic [mesf_pkg::THRESH_W-1:0]        i_threshold,
    output mesf_pkg::t_hist_rsp                  o_rsp
);
    import mesf_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] FULL    = CW'(HISTORY_DEPTH);
    localparam logic [CW-1:0] LAST    = CW'(HISTORY_DEPTH - 1);
    localparam logic [AW-1:0] PTR_TOP = AW'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {
        H_IDLE = 2'b01,
        H_SCAN = 2'b10
    } t_hstate;

    t_hstate                     r_state;
    logic [AW-1:0]               r_ptr;
    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               r_j;
    logic [CW-1:0]               r_k;
    logic                        r_rv;
    logic                        r_ok;
    logic                        r_done;
    logic                        r_stable;
    logic signed [SAMPLE_W-1:0]  r_avg;

    logic                        ram_re;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic [CW-1:0]               fill_next;
    logic signed [SAMPLE_W:0]    dev;
    logic [SAMPLE_W:0]           dev_mag;
    logic                        bad;

    mesf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.write),
        .i_waddr (r_ptr),
        .i_wdata (i_avg),
        .i_re    (ram_re),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ram_re    = (r_state == H_SCAN) && (r_j != FULL);
    assign fill_next = (r_fill == FULL) ? r_fill : r_fill + CW'(1);

    // deviation at full width: 33-bit difference never wraps
    assign dev     = $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                   - $signed({r_avg[SAMPLE_W-1], r_avg});
    assign dev_mag = dev[SAMPLE_W] ? -dev : dev;
    assign bad     = dev_mag > {2'b00, i_threshold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= H_IDLE;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_done   <= 1'b0;
            r_stable <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_req.clear) begin
                        r_ptr  <= '0;
                        r_fill <= '0;
                    end else if (i_req.write) begin
                        r_avg  <= i_avg;
                        r_fill <= fill_next;
                        r_ptr  <= (r_ptr == PTR_TOP) ? '0 : r_ptr + AW'(1);
                        if (fill_next == FULL) begin
                            r_j     <= '0;
                            r_k     <= '0;
                            r_rv    <= 1'b0;
                            r_ok    <= 1'b1;
                            r_state <= H_SCAN;
                        end else begin
                            r_done   <= 1'b1;
                            r_stable <= 1'b0;
                        end
                    end
                end
                H_SCAN: begin
                    // read address runs one ahead, so the read enable is low on the last compare
                    r_rv <= ram_re;
                    if (ram_re) begin
                        r_j <= r_j + CW'(1);
                    end
                    if (r_rv) begin
                        r_k <= r_k + CW'(1);
                        if (bad) begin
                            r_ok <= 1'b0;
                        end
                        if (r_k == LAST) begin
                            r_done   <= 1'b1;
                            r_stable <= r_ok && !bad;
                            r_state  <= H_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.stable = r_stable;

endmodule

[src/mesf_chk.sv]
module mesf_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 i_func,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [mesf_pkg::SAMPLE_W-1:0] o_filtered_weight,
    input logic                                 o_stable_flag
);
    import mesf_pkg::*;

    // out of reset: no result pending and ready for input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_filtered_weight) && $stable(o_stable_flag))
        else $error("stalled output beat changed");

    // a restart beat never yields a result
    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_func == FUNC_RESTART) && !o_out_valid
            |=> !o_out_valid)
        else $error("result after restart beat");

    // a new result only follows a busy phase of the block
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a window in progress");

endmodule

bind median_ema_stability_filter mesf_chk u_mesf_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_func            (i_func),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_filtered_weight (o_filtered_weight),
    .o_stable_flag     (o_stable_flag)
);

[tb/median_ema_stability_filter_tb.sv]
`timescale 1ns / 100ps

module median_ema_stability_filter_tb;
    import mesf_pkg::*;

    localparam int WIN        = WINDOW_SIZE_DEF;
    localparam int HIST       = HISTORY_DEPTH_DEF;
    localparam int DIR_N      = 24;
    localparam int PHASES     = 8;
    localparam int PHASE_BEATS = 200;
    localparam int SETTLE     = 80;       // margin for the slowest window close
    localparam int LIMIT      = 400000;

    localparam logic signed [SAMPLE_W-1:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SMIN = 32'sh8000_0000;
    localparam logic [THRESH_W-1:0]        TMAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] weight;
        logic                       stable;
    } t_avg_beat;

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] value;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] weight;
        logic                       stable;
    } t_dir_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_func;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_filtered_weight;
    logic                       o_stable_flag;

    median_ema_stability_filter #(
        .WINDOW_SIZE   (WIN),
        .HISTORY_DEPTH (HIST)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_sample_value    (i_sample_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_filtered_weight (o_filtered_weight),
        .o_stable_flag     (o_stable_flag)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // filter state mirror
    logic signed [SAMPLE_W-1:0] win_buf [WIN];
    int                         win_cnt;
    logic signed [SAMPLE_W-1:0] avg_q;
    bit                         avg_seeded;
    logic signed [SAMPLE_W-1:0] hist_buf [HIST];
    int                         hist_wr;
    int                         hist_cnt;
    logic [ALPHA_W-1:0]         alpha_q;
    logic [THRESH_W-1:0]        thresh_q;

    t_avg_beat owed_results [$];
    bit        no_idle;
    int        cycle_cnt;
    int        n_errors, n_beats, n_checked, n_restarts, n_stable, n_settings;

    t_dir_row dir_rows [DIR_N] = '{
        // extremes in one window: median lands on zero, first median seeds
        '{FUNC_SAMPLE,  SMAX,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMIN,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  32'sd0,    1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMAX,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMIN,      1'b1, 32'sd0, 1'b0},
        '{FUNC_RESTART, -32'sd1,   1'b0, 32'sd0, 1'b0},
        // reseeds at the top of the range
        '{FUNC_SAMPLE,  SMAX,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMAX,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMAX,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMAX,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMAX,      1'b1, SMAX,   1'b0},
        // blend from the top towards the bottom of the range
        '{FUNC_SAMPLE,  SMIN,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMIN,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMIN,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMIN,      1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  SMIN,      1'b0, 32'sd0, 1'b0},
        // partial window dropped by a restart
        '{FUNC_SAMPLE,  32'sd12345, 1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  -32'sd1,   1'b0, 32'sd0, 1'b0},
        '{FUNC_RESTART, 32'sd0,    1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  -32'sd256, 1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  -32'sd256, 1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  -32'sd256, 1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  -32'sd256, 1'b0, 32'sd0, 1'b0},
        '{FUNC_SAMPLE,  -32'sd256, 1'b1, -32'sd256, 1'b0}
    };

    task automatic clear_filter();
        win_cnt    = 0;
        avg_q      = '0;
        avg_seeded = 1'b0;
        for (int i = 0; i < HIST; i++) hist_buf[i] = '0;
        hist_wr    = 0;
        hist_cnt   = 0;
    endtask

    // one beat into the filter mirror; got is set when a window closes
    task automatic advance_filter(input logic f, input logic signed [SAMPLE_W-1:0] v,
                                  output bit got, output t_avg_beat res);
        logic signed [SAMPLE_W-1:0] srt [WIN];
        logic signed [SAMPLE_W-1:0] tmp, med;
        longint signed              a, s, d;
        bit                         ok;
        got = 1'b0;
        res = '0;
        if (f == FUNC_RESTART) begin
            clear_filter();
            return;
        end
        win_buf[win_cnt] = v;
        win_cnt++;
        if (win_cnt < WIN) return;
        win_cnt = 0;

        for (int i = 0; i < WIN; i++) srt[i] = win_buf[i];
        for (int i = 0; i < WIN - 1; i++)
            for (int j = 0; j < WIN - 1 - i; j++)
                if (srt[j] > srt[j+1]) begin
                    tmp = srt[j];
                    srt[j] = srt[j+1];
                    srt[j+1] = tmp;
                end
        med = srt[WIN/2];

        if (!avg_seeded) begin
            avg_q = med;
            avg_seeded = 1'b1;
        end else begin
            a = (alpha_q > ALPHA_ONE) ? 64'sd65536 : longint'(alpha_q);
            s = a * longint'(med) + (64'sd65536 - a) * longint'(avg_q);
            avg_q = SAMPLE_W'(s >>> FRAC_SHIFT);
        end

        hist_buf[hist_wr] = avg_q;
        hist_wr = (hist_wr + 1) % HIST;
        if (hist_cnt < HIST) hist_cnt++;

        ok = (hist_cnt >= HIST);
        if (ok)
            for (int i = 0; i < HIST; i++) begin
                d = longint'(hist_buf[i]) - longint'(avg_q);
                if (d < 0) d = -d;
                if (d > longint'(thresh_q)) ok = 1'b0;
            end

        got = 1'b1;
        res.weight = avg_q;
        res.stable = ok;
    endtask

    task automatic drive_beat(input logic f, input logic signed [SAMPLE_W-1:0] v,
                              input bit typed, input t_avg_beat typed_res);
        bit        got;
        t_avg_beat res;
        while (!no_idle && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_sample_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_beats++;
        if (f == FUNC_RESTART) n_restarts++;
        advance_filter(f, v, got, res);
        if (got) owed_results.push_back(typed ? typed_res : res);
    endtask

    // let every owed average come out and the block go quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_EMA_ALPHA) alpha_q = d[ALPHA_W-1:0];
        else                      thresh_q = d[THRESH_W-1:0];
    endtask

    // output side: random stall, compare each beat with the oldest owed average
    always @(posedge i_clk) begin
        t_avg_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %0d / %0d",
                             $time, o_filtered_weight, o_stable_flag);
                    n_errors++;
                end else begin
                    want = owed_results.pop_front();
                    n_checked++;
                    if (o_stable_flag) n_stable++;
                    if (o_filtered_weight !== want.weight) begin
                        $display("%0t: filtered_weight mismatch, expected %0d, actual %0d",
                                 $time, want.weight, o_filtered_weight);
                        n_errors++;
                    end
                    if (o_stable_flag !== want.stable) begin
                        $display("%0t: stable_flag mismatch, expected %0d, actual %0d",
                                 $time, want.stable, o_stable_flag);
                        n_errors++;
                    end
                end
            end
            i_out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 29);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("median_ema_stability_filter_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [ALPHA_W-1:0]         ph_alpha;
        logic [THRESH_W-1:0]        ph_thresh;
        int                         nz, r;
        bit                         full;
        logic signed [SAMPLE_W-1:0] lvl, v;
        logic                       f;
        t_avg_beat                  tres;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_SAMPLE;
        i_sample_value = '0;
        i_out_stall    = 1'b0;
        no_idle        = 1'b0;
        cycle_cnt      = 0;
        n_errors = 0; n_beats = 0; n_checked = 0;
        n_restarts = 0; n_stable = 0; n_settings = 1;
        alpha_q  = ALPHA_RESET;
        thresh_q = THRESH_RESET;
        for (int i = 0; i < WIN; i++) win_buf[i] = '0;
        clear_filter();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            tres.weight = dir_rows[i].weight;
            tres.stable = dir_rows[i].stable;
            drive_beat(dir_rows[i].func, dir_rows[i].value, dir_rows[i].typed, tres);
        end

        for (int p = 0; p < PHASES; p++) begin
            full = 1'b0;
            case (p)
                0: begin ph_alpha = ALPHA_RESET; ph_thresh = THRESH_RESET; nz = 64;  end
                1: begin ph_alpha = ALPHA_ONE;   ph_thresh = '0;           nz = 0;   end
                2: begin ph_alpha = 17'd1;       ph_thresh = TMAX; nz = 0; full = 1'b1; end
                3: begin ph_alpha = ALPHA_ONE;   ph_thresh = TMAX; nz = 0; full = 1'b1; end
                4: begin ph_alpha = '0;          ph_thresh = 31'd1000;     nz = 200; end
                5: begin ph_alpha = 17'h1FFFF;   ph_thresh = 31'd50;       nz = 16;  end
                6: begin
                    ph_alpha  = ALPHA_W'($urandom_range(65536, 1));
                    ph_thresh = THRESH_W'($urandom_range(4095));
                    nz = 32;
                end
                default: begin ph_alpha = ALPHA_RESET; ph_thresh = THRESH_RESET; nz = 100; end
            endcase
            drain();
            cfg_write(CFG_EMA_ALPHA, CFG_DATA_W'(ph_alpha));
            cfg_write(CFG_STABLE_THRESHOLD, CFG_DATA_W'(ph_thresh));
            n_settings++;
            no_idle = (p == 6);
            lvl = $signed($urandom) >>> $urandom_range(12);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                r = $urandom_range(99);
                f = FUNC_SAMPLE;
                if (r < 1) begin
                    f = FUNC_RESTART;
                    v = $urandom;
                end else if (r < 9 || full) begin
                    v = $urandom;
                end else begin
                    v = lvl + SAMPLE_W'($urandom_range(2 * nz)) - SAMPLE_W'(nz);
                end
                drive_beat(f, v, 1'b0, '0);
            end
        end
        no_idle = 1'b0;
        drain();

        $display("covered %0d input beats (%0d restarts) over %0d register settings",
                 n_beats, n_restarts, n_settings);
        $display("checked %0d averages, %0d of them flagged stable", n_checked, n_stable);
        if (n_errors == 0)
            $display("median_ema_stability_filter_tb: done, clean");
        else
            $display("median_ema_stability_filter_tb: done, errors");
        $finish;
    end

endmodule

[median_ema_stability_filter.f]
src/mesf_pkg.sv
src/mesf_ram.sv
src/mesf_median.sv
src/mesf_hist.sv
src/median_ema_stability_filter.sv
src/mesf_chk.sv
tb/median_ema_stability_filter_tb.sv
